// File: hw/rtl/kmp_pkg.sv
// kmp_pkg: shared widths, register indexes and control types for the
// streaming substring matcher. No dependencies.
package kmp_pkg;

   localparam int REG_BYTES   = 32;  // pattern bytes the registers supply
   localparam int WORD_COUNT  = 4;   // 64-bit pattern registers
   localparam int WORD_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int PAT_LEN_W   = 6;
   localparam int LEN_EXT_W   = 7;   // holds any effective length up to 64
   localparam int POS_W       = 32;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_BYTES_0_7      = 3'd1,
      CSR_BYTES_8_15     = 3'd2,
      CSR_BYTES_16_23    = 3'd3,
      CSR_BYTES_24_31    = 3'd4
   } csr_index_type;

   // one accepted text byte as seen by the tally stage
   typedef struct packed {
      logic advance;
      logic restart;
      logic found;
   } kmp_step_type;

endpackage

// File: hw/rtl/kmp_ifs.sv
// kmp_ifs: valid/ready channel interfaces for text, results and register
// writes. Depends on kmp_pkg.
interface kmp_req_if import kmp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              start_of_text;
   modport source (output valid, text_byte, start_of_text, input ready);
   modport sink   (input valid, text_byte, start_of_text, output ready);
endinterface

interface kmp_rsp_if import kmp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             match_found;
   logic [POS_W-1:0] match_start;
   logic [POS_W-1:0] matches_so_far;
   modport source (output valid, match_found, match_start, matches_so_far, input ready);
   modport sink   (input valid, match_found, match_start, matches_so_far, output ready);
endinterface

interface kmp_csr_if import kmp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/kmp_cell.sv
// kmp_cell: one compare cell of the match chain; holds whether the pattern
// prefix ending at this cell matched the text so far. Depends on kmp_pkg.
module kmp_cell import kmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              flush,
   input  logic              link_in,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic [BYTE_W-1:0] pattern_byte,
   output logic              hit_next,
   output logic              hit_q
);

   logic hit_ff;
   logic hit_in;

   assign hit_next = link_in & (text_byte == pattern_byte);

   always_comb begin
      hit_in = hit_ff;
      if (flush) begin
         hit_in = 1'b0;
      end else if (advance) begin
         hit_in = hit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit_q = hit_ff;

endmodule

// File: hw/rtl/kmp_tally.sv
// kmp_tally: text position, saturating match count and the result register.
// Depends on kmp_pkg and kmp_rsp_if.
module kmp_tally import kmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  kmp_step_type     step,
   input  logic [POS_W-1:0] span,
   output logic             space,
   kmp_rsp_if.source        rsp_bus
);

   localparam logic [POS_W-1:0] SAT = {POS_W{1'b1}};

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic             valid_ff, valid_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_cur;
   logic [POS_W-1:0] total_cur;
   logic [POS_W-1:0] total_new;

   assign space = ~valid_ff | rsp_bus.ready;

   always_comb begin
      pos_cur   = step.restart ? '0 : pos_ff;
      total_cur = step.restart ? '0 : total_ff;
      total_new = (step.found && total_cur != SAT) ? total_cur + 1'b1 : total_cur;

      pos_in   = pos_ff;
      total_in = total_ff;
      valid_in = valid_ff & ~rsp_bus.ready;
      found_in = found_ff;
      start_in = start_ff;
      count_in = count_ff;
      if (step.advance) begin
         pos_in   = (pos_cur == SAT) ? pos_cur : pos_cur + 1'b1;
         total_in = total_new;
         valid_in = 1'b1;
         found_in = step.found;
         start_in = step.found ? pos_cur - span : '0;
         count_in = total_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      found_ff <= found_in;
      start_ff <= start_in;
      count_ff <= count_in;
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.match_found    = found_ff;
   assign rsp_bus.match_start    = start_ff;
   assign rsp_bus.matches_so_far = count_ff;

endmodule

// File: hw/rtl/kmp_substring_matcher.sv
// kmp_substring_matcher: streaming substring search over a chain of compare
// cells, one per pattern byte. Depends on kmp_pkg, kmp_ifs, kmp_cell, kmp_tally.
//
//   channel  | dir | beat
//   ---------+-----+-------------------------------------------------
//   req_bus  | in  | text_byte, start_of_text
//   rsp_bus  | out | match_found, match_start, matches_so_far
//   csr_bus  | in  | index (0 length, 1..4 pattern bytes), data
//
// One text beat per cycle; each beat shifts every cell's hit bit one place
// down the chain, so a result leaves in the cycle after its beat is taken.
// The single result register throttles intake when rsp_bus stalls.
// Reset: length 1, pattern bytes zero, position and count zero.
// A write to index 0..4 clears all cell hits; csr_bus never stalls.
module kmp_substring_matcher import kmp_pkg::*; #(
   parameter int MAX_PATTERN = 32
) (
   input  logic      clock,
   input  logic      reset,
   kmp_req_if.sink   req_bus,
   kmp_rsp_if.source rsp_bus,
   kmp_csr_if.sink   csr_bus
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [PAT_LEN_W-1:0]                pattern_length_ff, pattern_length_in;
   logic [WORD_COUNT-1:0][WORD_W-1:0]   pattern_words_ff, pattern_words_in;
   logic                                flush;
   logic                                advance;
   logic                                tally_space;
   logic [LEN_EXT_W-1:0]                len_ext;
   logic [LEN_EXT_W-1:0]                eff_len;
   logic [IDX_W-1:0]                    last_idx;
   logic [POS_W-1:0]                    span;
   logic [MAX_PATTERN-1:0]              link;
   logic [MAX_PATTERN-1:0]              hit_next;
   logic [MAX_PATTERN-1:0]              hit_q;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]  pat_byte;
   kmp_step_type                        step;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      pattern_length_in = pattern_length_ff;
      pattern_words_in  = pattern_words_ff;
      flush             = 1'b0;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_bus.data[PAT_LEN_W-1:0];
               flush             = 1'b1;
            end
            CSR_BYTES_0_7: begin
               pattern_words_in[0] = csr_bus.data;
               flush               = 1'b1;
            end
            CSR_BYTES_8_15: begin
               pattern_words_in[1] = csr_bus.data;
               flush               = 1'b1;
            end
            CSR_BYTES_16_23: begin
               pattern_words_in[2] = csr_bus.data;
               flush               = 1'b1;
            end
            CSR_BYTES_24_31: begin
               pattern_words_in[3] = csr_bus.data;
               flush               = 1'b1;
            end
            default: begin
               flush = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= PAT_LEN_W'(1);
         pattern_words_ff  <= '0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         pattern_words_ff  <= pattern_words_in;
      end
   end

   // clamp length into 1..MAX_PATTERN
   always_comb begin
      len_ext = {1'b0, pattern_length_ff};
      if (len_ext == '0) begin
         eff_len = LEN_EXT_W'(1);
      end else if (len_ext > LEN_EXT_W'(MAX_PATTERN)) begin
         eff_len = LEN_EXT_W'(MAX_PATTERN);
      end else begin
         eff_len = len_ext;
      end
   end

   assign last_idx = IDX_W'(eff_len - 1'b1);
   assign span     = POS_W'(eff_len - 1'b1);

   assign req_bus.ready = tally_space;
   assign advance       = req_bus.valid & tally_space;

   // cell chain
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      localparam int WORD_SEL = k / 8;
      localparam int BYTE_SEL = k % 8;
      if (k < REG_BYTES) begin : g_reg
         assign pat_byte[k] = pattern_words_ff[WORD_SEL][BYTE_SEL*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign pat_byte[k] = '0;
      end
      if (k == 0) begin : g_head
         assign link[k] = 1'b1;
      end else begin : g_body
         // drop the prior hit when the text restarts at this beat
         assign link[k] = hit_q[k-1] & ~req_bus.start_of_text;
      end
      kmp_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .flush        (flush),
         .link_in      (link[k]),
         .text_byte    (req_bus.text_byte),
         .pattern_byte (pat_byte[k]),
         .hit_next     (hit_next[k]),
         .hit_q        (hit_q[k])
      );
   end

   assign step.advance = advance;
   assign step.restart = req_bus.start_of_text;
   assign step.found   = hit_next[last_idx];

   kmp_tally u_tally (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .span    (span),
      .space   (tally_space),
      .rsp_bus (rsp_bus)
   );

   a_found_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.match_found |-> rsp_bus.matches_so_far != '0)
      else $error("match reported with zero count");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.match_found |-> rsp_bus.match_start == '0)
      else $error("start position set without a match");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      flush |=> hit_q == '0)
      else $error("cell hits survive a register write");

   a_restart_head: assert property (@(posedge clock) disable iff (reset)
      advance && req_bus.start_of_text && !flush |=> $countones(hit_q) <= 1)
      else $error("restart left deeper prefix hits");

endmodule

// File: tb/kmp_match_checker.sv
// kmp_match_checker: watches the text, result and register channels of the
// substring matcher, predicts every result and compares. Depends on kmp_pkg, kmp_ifs.
module kmp_match_checker import kmp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic done,
   kmp_req_if   req_mon,
   kmp_rsp_if   rsp_mon,
   kmp_csr_if   csr_mon,
   output int   results_seen,
   output int   failures
);

   localparam int MAX_LEN = 32;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] count;
   } match_result_type;

   logic [WORD_W-1:0]    pattern_words [WORD_COUNT];
   logic [PAT_LEN_W-1:0] length_reg;
   logic [BYTE_W-1:0]    pattern [MAX_LEN];
   logic [4:0]           fail_link [MAX_LEN];
   int unsigned          span;
   int unsigned          prefix_len;
   logic [POS_W-1:0]     position;
   logic [POS_W-1:0]     total;
   match_result_type     expected_matches [$];
   int                   reported;
   bit                   leftover_checked;

   function automatic void rebuild_pattern();
      int unsigned i;
      int unsigned k;
      if (length_reg == 0) span = 1;
      else if (length_reg > MAX_LEN) span = MAX_LEN;
      else span = length_reg;
      for (i = 0; i < MAX_LEN; i++) begin
         pattern[i]   = pattern_words[i / 8][8 * (i % 8) +: 8];
         fail_link[i] = '0;
      end
      // prefix function: longest proper border of each pattern prefix
      k = 0;
      for (i = 1; i < span; i++) begin
         while (k > 0 && pattern[i] != pattern[k]) k = fail_link[k - 1];
         if (pattern[i] == pattern[k]) k++;
         fail_link[i] = k[4:0];
      end
      prefix_len = 0;
   endfunction

   function automatic match_result_type scan_byte(logic [BYTE_W-1:0] c, logic restart);
      match_result_type r;
      int unsigned j;
      if (restart) begin
         prefix_len = 0;
         position   = '0;
         total      = '0;
      end
      r = '0;
      j = prefix_len;
      if (j >= span) j = 0;
      while (j > 0 && pattern[j] != c) j = fail_link[j - 1];
      if (pattern[j] == c) j++;
      if (j == span) begin
         r.found = 1'b1;
         r.start = position - POS_W'(span - 1);
         if (total != '1) total++;
         // keep overlapping matches alive
         j = fail_link[j - 1];
      end
      r.count    = total;
      prefix_len = j;
      if (position != '1) position++;
      return r;
   endfunction

   always @(posedge clock) begin
      match_result_type want;
      match_result_type got;
      if (reset) begin
         length_reg = 1;
         for (int w = 0; w < WORD_COUNT; w++) pattern_words[w] = '0;
         position = '0;
         total    = '0;
         rebuild_pattern();
         expected_matches.delete();
         results_seen <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index) inside
               CSR_PATTERN_LENGTH: begin
                  length_reg = csr_mon.data[PAT_LEN_W-1:0];
                  rebuild_pattern();
               end
               CSR_BYTES_0_7, CSR_BYTES_8_15, CSR_BYTES_16_23, CSR_BYTES_24_31: begin
                  pattern_words[csr_mon.index - CSR_BYTES_0_7] = csr_mon.data;
                  rebuild_pattern();
               end
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.found    = rsp_mon.match_found;
            got.start    = rsp_mon.match_start;
            got.count    = rsp_mon.matches_so_far;
            results_seen <= results_seen + 1;
            if (expected_matches.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected result beat: found=%0b start=%0d count=%0d",
                           got.found, got.start, got.count);
               end
            end else begin
               want = expected_matches.pop_front();
               if (got.found !== want.found || got.start !== want.start ||
                   got.count !== want.count) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("result %0d mismatch: expected found=%0b start=%0d count=%0d,",
                              results_seen, want.found, want.start, want.count,
                              " got found=%0b start=%0d count=%0d",
                              got.found, got.start, got.count);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_matches.insert(expected_matches.size(),
                                    scan_byte(req_mon.text_byte, req_mon.start_of_text));
         if (done && !leftover_checked) begin
            leftover_checked = 1;
            if (expected_matches.size() != 0) begin
               failures += expected_matches.size();
               $display("%0d expected results never arrived", expected_matches.size());
            end
         end
      end
   end

endmodule

// File: tb/kmp_substring_matcher_tb.sv
// kmp_substring_matcher_tb: drives text and register writes into the matcher
// and gives the verdict. Depends on kmp_pkg, kmp_ifs, kmp_match_checker.
module kmp_substring_matcher_tb import kmp_pkg::*; ();

   localparam int MAX_LEN      = 32;
   localparam int RANDOM_ITEMS = 1900;
   localparam int LIMIT        = 400000;

   logic clock;
   logic reset;
   logic done;
   int   results_seen;
   int   failures;
   int   items_sent;
   int   cycle_count;
   bit   steady;

   logic [WORD_W-1:0]    word_copy [WORD_COUNT];
   logic [WORD_W-1:0]    word_held [WORD_COUNT];
   logic [PAT_LEN_W-1:0] len_copy;
   logic [BYTE_W-1:0]    pat_copy [MAX_LEN];
   int                   pat_span;
   logic [BYTE_W-1:0]    text_plan [$];

   kmp_req_if req_bus ();
   kmp_rsp_if rsp_bus ();
   kmp_csr_if csr_bus ();

   kmp_substring_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   kmp_match_checker match_check (
      .clock        (clock),
      .reset        (reset),
      .done         (done),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .results_seen (results_seen),
      .failures     (failures)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** kmp_substring_matcher: FAILED **");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_bus.ready <= steady || ($urandom_range(99) >= 34);

   task automatic send_text(input logic [BYTE_W-1:0] b, input logic restart);
      while (!steady && $urandom_range(99) < 34) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.text_byte     <= b;
      req_bus.start_of_text <= restart;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [WORD_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Drain all results, then write any stray indexes, the length and the masked pattern words.
   task automatic program_matcher(input bit [WORD_COUNT-1:0] word_mask, input bit with_stray);
      logic [WORD_W-1:0] len_data;
      bit length_last;
      req_bus.valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
      repeat (3) @(posedge clock);
      if (with_stray)
         for (int idx = CSR_BYTES_24_31 + 1; idx < (1 << CSR_INDEX_W); idx++)
            csr_write(CSR_INDEX_W'(idx), {$urandom(), $urandom()});
      len_data = {$urandom(), $urandom()};
      len_data[PAT_LEN_W-1:0] = len_copy;
      length_last = $urandom_range(1);
      if (!length_last) csr_write(CSR_PATTERN_LENGTH, len_data);
      for (int w = 0; w < WORD_COUNT; w++)
         if (word_mask[w]) begin
            csr_write(CSR_INDEX_W'(CSR_BYTES_0_7 + w), word_copy[w]);
            word_held[w] = word_copy[w];
         end
      if (length_last) csr_write(CSR_PATTERN_LENGTH, len_data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < MAX_LEN; i++) pat_copy[i] = word_held[i / 8][8 * (i % 8) +: 8];
      if (len_copy == 0) pat_span = 1;
      else if (len_copy > MAX_LEN) pat_span = MAX_LEN;
      else pat_span = len_copy;
   endtask

   task automatic load_pattern(input string p, input logic [PAT_LEN_W-1:0] len_field);
      for (int w = 0; w < WORD_COUNT; w++) word_copy[w] = '0;
      for (int i = 0; i < p.len(); i++) word_copy[i / 8][8 * (i % 8) +: 8] = p[i];
      len_copy = len_field;
      program_matcher('1, 0);
   endtask

   task automatic send_string(input string s, input bit restart);
      for (int i = 0; i < s.len(); i++) send_text(s[i], restart && i == 0);
   endtask

   // Queue the next stretch of text: whole pattern copies, broken prefixes,
   // bytes from the pattern's own alphabet, or noise.
   function automatic void plan_text();
      int r;
      int n;
      r = $urandom_range(99);
      n = 0;
      if (r < 30) n = pat_span;
      else if (r < 45) n = $urandom_range(pat_span, 1);
      for (int i = 0; i < n; i++) text_plan.insert(text_plan.size(), pat_copy[i]);
      if (n == 0) begin
         if (r < 90)
            text_plan.insert(text_plan.size(), pat_copy[$urandom_range(pat_span - 1)]);
         else
            text_plan.insert(text_plan.size(), BYTE_W'($urandom_range(255)));
      end
   endfunction

   initial begin
      int   pick;
      int   phase;
      int   phase_items;
      int   alphabet_size;
      logic [BYTE_W-1:0] alphabet [3];
      bit   narrow;
      logic [BYTE_W-1:0] b;

      reset                 = 1'b1;
      done                  = 1'b0;
      steady                = 0;
      items_sent            = 0;
      req_bus.valid         = 1'b0;
      req_bus.text_byte     = '0;
      req_bus.start_of_text = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_PATTERN_LENGTH;
      csr_bus.data          = '0;
      for (int w = 0; w < WORD_COUNT; w++) word_copy[w] = '0;
      for (int w = 0; w < WORD_COUNT; w++) word_held[w] = '0;
      len_copy = 1;
      pat_span = 1;
      for (int i = 0; i < MAX_LEN; i++) pat_copy[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: one zero byte
      send_text(8'h00, 1'b1);
      send_text(8'hFF, 1'b0);
      send_text(8'h00, 1'b0);
      send_text(8'h80, 1'b0);

      // stray register indexes, zero length acting as one; position and count carry on
      word_copy[0] = 64'hFF;
      for (int w = 1; w < WORD_COUNT; w++) word_copy[w] = '0;
      len_copy = 0;
      program_matcher('1, 1);
      send_text(8'hFF, 1'b0);
      send_text(8'hFF, 1'b0);

      // overlapping matches, then a restart
      load_pattern("aaa", 3);
      send_string("aaaaa", 1);
      send_text("a", 1'b1);

      load_pattern("abab", 4);
      send_string("xababab", 0);

      phase = 0;
      while (items_sent < RANDOM_ITEMS + 19) begin
         pick = $urandom_range(99);
         if (pick < 10) len_copy = 0;
         else if (pick < 20) len_copy = 1;
         else if (pick < 35) len_copy = MAX_LEN;
         else if (pick < 45) len_copy = $urandom_range((1 << PAT_LEN_W) - 1, MAX_LEN + 1);
         else if (pick < 75) len_copy = $urandom_range(6, 2);
         else len_copy = $urandom_range(MAX_LEN - 1, 7);

         narrow        = $urandom_range(99) < 70;
         alphabet_size = $urandom_range(3, 1);
         for (int a = 0; a < 3; a++) alphabet[a] = BYTE_W'($urandom_range(255));
         for (int i = 0; i < MAX_LEN; i++) begin
            b = narrow ? alphabet[$urandom_range(alphabet_size - 1)]
                       : BYTE_W'($urandom_range(255));
            word_copy[i / 8][8 * (i % 8) +: 8] = b;
         end
         if (phase == 0) program_matcher('1, 0);
         else program_matcher(WORD_COUNT'($urandom()) | WORD_COUNT'($urandom()) |
                              WORD_COUNT'($urandom()), $urandom_range(99) < 10);

         phase_items = $urandom_range(140, 40);
         text_plan.delete();
         for (int n = 0; n < phase_items; n++) begin
            if (text_plan.size() == 0) plan_text();
            steady = items_sent >= 800 && items_sent < 1200;
            send_text(text_plan.pop_front(),
                      n == 0 ? logic'($urandom_range(1)) : logic'($urandom_range(99) < 2));
         end
         phase++;
      end

      req_bus.valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      done <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0)
         $display("** kmp_substring_matcher: PASSED **");
      else
         $display("** kmp_substring_matcher: FAILED **");
      $finish;
   end

endmodule

// File: kmp_substring_matcher.f
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_ifs.sv
hw/rtl/kmp_cell.sv
hw/rtl/kmp_tally.sv
hw/rtl/kmp_substring_matcher.sv
tb/kmp_match_checker.sv
tb/kmp_substring_matcher_tb.sv
